// ===== hw/rtl/bm3_pkg.sv =====
// bm3_pkg: shared constants and types for the 3x3 binary morphology block
// no dependencies; imported by bm3_ram users and binary_morphology_3x3
`timescale 1ns / 1ps
`default_nettype none

package bm3_pkg;

  // geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_CAP    = 1024;
  localparam int WIN_SIZE      = 3;
  localparam int WIN_BITS      = WIN_SIZE * WIN_SIZE;
  localparam int MIN_DIM       = 3;

  // field widths
  localparam int PIX_W   = 8;
  localparam int POS_W   = 10;
  localparam int DIM_W   = 11;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;

  localparam logic [PIX_W-1:0] SET_LEVEL = 8'd255;
  localparam logic [PIX_W-1:0] CLR_LEVEL = 8'd0;

  typedef enum logic [CIDX_W-1:0] {
    CFG_OP_MODE = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } op_mode_t;

  // register reset values
  localparam op_mode_t             OP_MODE_RST = MODE_DILATE;
  localparam logic [WIN_BITS-1:0]  MASK_RST    = '0;
  localparam logic [DIM_W-1:0]     WIDTH_RST   = 11'd640;
  localparam logic [DIM_W-1:0]     HEIGHT_RST  = 11'd480;

endpackage

`default_nettype wire

// ===== hw/rtl/bm3_ram.sv =====
// bm3_ram: generic simple dual-port ram, one write and one registered read port
// read returns the old contents on a same-address write; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module bm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/binary_morphology_3x3.sv =====
// binary_morphology_3x3: streaming 3x3 binary erosion / dilation on raster pixels
// depends on bm3_pkg and bm3_ram (two line stores packed in one 2-bit wide ram)
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_pixel_in, in_frame_start | request in
//  out     | out_valid, out_stall, out_pixel_out,            | request out
//          | out_row, out_col                                |
//  cfg     | cfg_we, cfg_index, cfg_data                     | write only
//
// one pixel per clock sustained while out_stall does not hold the output; a result is
// registered in stage 1 (line store read with the pixel), then window update into the output register
// reset: synchronous rst_n; line stores need no clearing pass, a fill count marks
// which columns hold data and unwritten columns read as zero
// a stalled result holds the output register; in_stall rises only when the
// pending pixel has a result and the output register cannot take it
`timescale 1ns / 1ps
`default_nettype none

module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pixel in
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bm3_pkg::PIX_W-1:0]   in_pixel_in,
  input  wire logic                        in_frame_start,
  // result out
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [bm3_pkg::PIX_W-1:0]   out_pixel_out,
  output logic      [bm3_pkg::POS_W-1:0]   out_row,
  output logic      [bm3_pkg::POS_W-1:0]   out_col,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [bm3_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [bm3_pkg::CFG_W-1:0]   cfg_data
);

  import bm3_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > DIM_W) ? WW : DIM_W;
  localparam int HW   = $clog2(HEIGHT_CAP + 1);

  // configuration registers
  op_mode_t              op_mode_r;
  logic [WIN_BITS-1:0]   mask_r;
  logic [DIM_W-1:0]      width_r;
  logic [DIM_W-1:0]      height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= OP_MODE_RST;
      mask_r    <= MASK_RST;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OP_MODE: op_mode_r <= op_mode_t'(cfg_data[0]);
        CFG_MASK:    mask_r    <= cfg_data[WIN_BITS-1:0];
        CFG_WIDTH:   width_r   <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:  height_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry, clamped
  logic [CMPW-1:0] w_raw, w_eff;
  logic [HW-1:0]   h_eff;

  always_comb begin
    w_raw = CMPW'(width_r);
    if (w_raw < CMPW'(MIN_DIM)) begin
      w_eff = CMPW'(MIN_DIM);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_r < DIM_W'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (height_r > DIM_W'(HEIGHT_CAP)) begin
      h_eff = HW'(HEIGHT_CAP);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  // handshake control
  logic in_accept, out_free, s1_move;
  logic s1_valid_r, s1_emit_r;

  assign out_free  = !out_valid || !out_stall;
  assign s1_move   = s1_valid_r && (!s1_emit_r || out_free);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  // position counters
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt, col_in;
  logic [POS_W-1:0] row_cnt_r, row_cnt_nxt, row_in;
  logic [CMPW-1:0]  col_inc;
  logic [HW-1:0]    row_inc;
  logic             emit_in;
  logic [CW+POS_W-1:0] col_m1_ext;
  logic [POS_W-1:0] col_m1, row_m1;

  always_comb begin
    col_in  = in_frame_start ? '0 : col_cnt_r;
    row_in  = in_frame_start ? '0 : row_cnt_r;
    col_inc = CMPW'(col_in) + CMPW'(1);
    row_inc = HW'(row_in) + HW'(1);
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = (HW'(row_in) >= h_eff) ? '0 : row_in;
    end
    emit_in    = (row_in >= POS_W'(2)) && (col_in >= CW'(2));
    col_m1_ext = {{POS_W{1'b0}}, col_in - CW'(1)};
    col_m1     = col_m1_ext[POS_W-1:0];
    row_m1     = row_in - POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // stage 1: line store data comes back, window shifts
  logic [CW-1:0]    s1_col_r;
  logic             s1_cur_r;
  logic [POS_W-1:0] s1_row_m1_r, s1_col_m1_r;
  logic [1:0]       ram_rdata, ram_wdata, s1_lines;
  logic             fwd_r;
  logic [1:0]       fwd_data_r;
  logic [WW-1:0]    fill_r;
  logic             top_bit, mid_bit;

  bm3_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (col_in),
    .rdata (ram_rdata)
  );

  // bit 1: row before last, bit 0: last row
  always_comb begin
    if (fwd_r) begin
      s1_lines = fwd_data_r;
    end else if (WW'(s1_col_r) < fill_r) begin
      s1_lines = ram_rdata;
    end else begin
      s1_lines = '0;
    end
    top_bit   = s1_lines[1];
    mid_bit   = s1_lines[0];
    ram_wdata = {mid_bit, s1_cur_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      fwd_r      <= 1'b0;
      fill_r     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        s1_emit_r  <= emit_in;
        // same column written back this cycle: ram read returns stale data
        fwd_r      <= s1_move && (col_in == s1_col_r);
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
        s1_emit_r  <= 1'b0;
        fwd_r      <= 1'b0;
      end
      // written columns always form a prefix starting at column zero
      if (s1_move && (WW'(s1_col_r) == fill_r)) begin
        fill_r <= fill_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r    <= col_in;
      s1_cur_r    <= (in_pixel_in == SET_LEVEL);
      s1_row_m1_r <= row_m1;
      s1_col_m1_r <= col_m1;
      fwd_data_r  <= ram_wdata;
    end
  end

  // window, bit row*3+col; new column enters on the right
  logic [WIN_BITS-1:0] win_r, win_nxt, sel;
  logic                hit;

  always_comb begin
    win_nxt = {s1_cur_r, win_r[8:7], mid_bit, win_r[5:4], top_bit, win_r[2:1]};
    sel     = win_nxt & mask_r;
    case (op_mode_r)
      MODE_DILATE: hit = |sel;
      MODE_ERODE:  hit = (sel == mask_r);
      default:     hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_move) begin
      win_r <= win_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_emit_r) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit_r) begin
      out_pixel_out <= hit ? SET_LEVEL : CLR_LEVEL;
      out_row       <= s1_row_m1_r;
      out_col       <= s1_col_m1_r;
    end
  end

endmodule

`default_nettype wire
